// ===== rtl/core/rsi_pkg.sv =====
// Shared types, widths and helpers for the ray/sphere intersection pipeline.
package rsi_pkg;

	// Register map of the configuration port
	localparam int CFG_IW = 3;
	typedef enum logic [CFG_IW-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_RADIUS     = 3'd3,
		REG_MATERIAL   = 3'd4,
		REG_MIN_DIST   = 3'd5,
		REG_DISC_THR   = 3'd6
	} reg_idx_t;

	// Square root unit: radicand and root widths
	localparam int SQ_W = 72;
	localparam int RT_W = SQ_W / 2;

	// Normal divider: magnitude, fraction and quotient widths
	localparam int DV_NW = 32;
	localparam int DV_FW = 16;
	localparam int DV_RW = DV_NW + DV_FW;
	localparam int DV_QW = DV_FW + 1;

	typedef logic signed [32:0] oc_t;
	typedef logic signed [17:0] dir_t;
	typedef logic signed [31:0] loc_t;
	typedef logic signed [37:0] dist_t;

	// Sideband carried alongside the discriminant square root
	typedef struct packed {
		logic             hit;
		logic signed [35:0] b;
		oc_t [2:0]        oc;
		dir_t [2:0]       d;
	} sqa_t;

	// Sideband carried alongside the normal length square root
	typedef struct packed {
		logic       hit;
		dist_t      t;
		loc_t [2:0] loc;
	} sqb_t;

	// Sideband carried alongside the normal dividers
	typedef struct packed {
		logic       hit;
		logic       lenz;
		dist_t      t;
		loc_t [2:0] loc;
	} dvb_t;

	function automatic logic [31:0] mag33(input oc_t v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input loc_t v);
		logic [31:0] n;
		n = -v;
		return v[31] ? n : v;
	endfunction

	function automatic loc_t sat41(input logic signed [40:0] v);
		if ((v[40:31] == '0) || (v[40:31] == '1)) begin
			return v[31:0];
		end
		return v[40] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
	endfunction

endpackage

// ===== rtl/core/ray_sphere_intersect.sv =====
// Ray/sphere intersection pipeline: top level with configuration registers.
// Intersects one ray per cycle, unless stalled, with a configured sphere (Q16.16
// fixed point) and returns hit flag, distance, unit normal, hit point relative
// to the center and material for every ray, misses included (all fields zero).
// The pipeline has 14 arithmetic stages, two 36-stage square-root units
// (discriminant and normal length) and a 17-stage divider for the normal, plus
// the output register. When the output is stalled the pipeline keeps accepting
// rays until its last stage is occupied. Write configuration only while no rays
// are in flight.
module ray_sphere_intersect (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rsi_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           ray_origin_x,
	input  logic signed [31:0]           ray_origin_y,
	input  logic signed [31:0]           ray_origin_z,
	input  logic signed [17:0]           ray_dir_x,
	input  logic signed [17:0]           ray_dir_y,
	input  logic signed [17:0]           ray_dir_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_hit,
	output logic [30:0]                  hit_distance,
	output logic signed [17:0]           normal_x,
	output logic signed [17:0]           normal_y,
	output logic signed [17:0]           normal_z,
	output logic signed [31:0]           local_x,
	output logic signed [31:0]           local_y,
	output logic signed [31:0]           local_z,
	output logic [7:0]                   hit_material
);
	import rsi_pkg::*;

	// Configuration
	loc_t        center_q [3];
	logic [30:0] radius_q;
	logic [7:0]  material_q;
	logic [30:0] min_dist_q;
	logic [30:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			radius_q    <= 31'd65536;
			material_q  <= '0;
			min_dist_q  <= '0;
			thr_q       <= 31'd7;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_RADIUS:   radius_q    <= cfg_data[30:0];
				REG_MATERIAL: material_q  <= cfg_data[7:0];
				REG_MIN_DIST: min_dist_q  <= cfg_data[30:0];
				REG_DISC_THR: thr_q       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Flow control: advance whenever the last stage is empty or can drain
	logic adv;
	logic load_out;
	logic [DV_QW-1:0] vd_s;

	assign load_out = !out_valid || out_ready;
	assign adv      = load_out || !vd_s[DV_QW-1];
	assign in_ready = adv;

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic [RT_W-1:0] v1_s;
	logic [RT_W-1:0] v2_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
			v1_s  <= '0;
			v2_s  <= '0;
			vd_s  <= '0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;  v_s3  <= v_s2;  v_s4  <= v_s3;  v_s5  <= v_s4;
			v_s6  <= v_s5;  v_s7  <= v_s6;
			v1_s  <= {v1_s[RT_W-2:0], v_s7};
			v_s8  <= v1_s[RT_W-1];
			v_s9  <= v_s8;  v_s10 <= v_s9;  v_s11 <= v_s10; v_s12 <= v_s11;
			v_s13 <= v_s12; v_s14 <= v_s13;
			v2_s  <= {v2_s[RT_W-2:0], v_s14};
			vd_s  <= {vd_s[DV_QW-2:0], v2_s[RT_W-1]};
		end
	end

	// Stage 1: offset from center
	oc_t [2:0]  oc_s1;
	dir_t [2:0] d_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			oc_s1[0] <= 33'(ray_origin_x) - 33'(center_q[0]);
			oc_s1[1] <= 33'(ray_origin_y) - 33'(center_q[1]);
			oc_s1[2] <= 33'(ray_origin_z) - 33'(center_q[2]);
			d_s1[0]  <= ray_dir_x;
			d_s1[1]  <= ray_dir_y;
			d_s1[2]  <= ray_dir_z;
		end
	end

	// Stage 2: dot-product terms, squared offsets, squared radius
	logic signed [50:0] pd_s2 [3];
	logic [63:0]        oq_s2 [3];
	logic [61:0]        r2_s2;
	oc_t [2:0]          oc_s2;
	dir_t [2:0]         d_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= 51'(oc_s1[i]) * 51'(d_s1[i]);
				oq_s2[i] <= 64'(mag33(oc_s1[i])) * 64'(mag33(oc_s1[i]));
			end
			r2_s2 <= 62'(radius_q) * 62'(radius_q);
			oc_s2 <= oc_s1;
			d_s2  <= d_s1;
		end
	end

	// Stage 3: b = floor(oc.d / 2^16), |oc|^2
	logic signed [52:0] dsum;
	logic signed [35:0] b_s3;
	logic [65:0]        q_s3;
	logic [61:0]        r2_s3;
	oc_t [2:0]          oc_s3;
	dir_t [2:0]         d_s3;

	assign dsum = 53'(pd_s2[0]) + 53'(pd_s2[1]) + 53'(pd_s2[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3  <= 36'(dsum >>> 16);
			q_s3  <= 66'(oq_s2[0]) + 66'(oq_s2[1]) + 66'(oq_s2[2]);
			r2_s3 <= r2_s2;
			oc_s3 <= oc_s2;
			d_s3  <= d_s2;
		end
	end

	// Stage 4: partial products of b*b, r^2 - |oc|^2
	logic [35:0]        bm;
	logic [35:0]        bneg;
	logic [35:0]        bhh_s4, bhl_s4, bll_s4;
	logic signed [73:0] rq_s4;
	logic signed [35:0] b_s4;
	oc_t [2:0]          oc_s4;
	dir_t [2:0]         d_s4;

	assign bneg = -b_s3;
	assign bm   = b_s3[35] ? bneg : b_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			bhh_s4 <= 36'(bm[35:18]) * 36'(bm[35:18]);
			bhl_s4 <= 36'(bm[35:18]) * 36'(bm[17:0]);
			bll_s4 <= 36'(bm[17:0]) * 36'(bm[17:0]);
			rq_s4  <= $signed({12'b0, r2_s3}) - $signed({8'b0, q_s3});
			b_s4   <= b_s3;
			oc_s4  <= oc_s3;
			d_s4   <= d_s3;
		end
	end

	// Stage 5: assemble b*b
	logic [71:0]        b2_s5;
	logic signed [73:0] rq_s5;
	logic signed [35:0] b_s5;
	oc_t [2:0]          oc_s5;
	dir_t [2:0]         d_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			b2_s5 <= (72'(bhh_s4) << 36) + (72'(bhl_s4) << 19) + 72'(bll_s4);
			rq_s5 <= rq_s4;
			b_s5  <= b_s4;
			oc_s5 <= oc_s4;
			d_s5  <= d_s4;
		end
	end

	// Stage 6: discriminant
	logic signed [73:0] dd_s6;
	logic signed [35:0] b_s6;
	oc_t [2:0]          oc_s6;
	dir_t [2:0]         d_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s6 <= $signed({2'b00, b2_s5}) + rq_s5;
			b_s6  <= b_s5;
			oc_s6 <= oc_s5;
			d_s6  <= d_s5;
		end
	end

	// Stage 7: threshold test; zero the radicand on a miss
	logic               hit0_s7;
	logic [SQ_W-1:0]    rad_s7;
	logic signed [35:0] b_s7;
	oc_t [2:0]          oc_s7;
	dir_t [2:0]         d_s7;
	logic               disc_ok;

	assign disc_ok = !dd_s6[73] && (dd_s6[72:0] >= 73'({thr_q, 16'b0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			hit0_s7 <= disc_ok;
			rad_s7  <= disc_ok ? dd_s6[SQ_W-1:0] : '0;
			b_s7    <= b_s6;
			oc_s7   <= oc_s6;
			d_s7    <= d_s6;
		end
	end

	// Discriminant square root with sideband line
	logic [RT_W-1:0] root1;
	sqa_t            sq1_s [RT_W];

	rsi_isqrt u_sqrt_disc (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s7),
		.root (root1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1_s[0] <= '{hit: hit0_s7, b: b_s7, oc: oc_s7, d: d_s7};
			for (int k = 1; k < RT_W; k++) begin
				sq1_s[k] <= sq1_s[k-1];
			end
		end
	end

	// Stage 8: both roots
	sqa_t  sa;
	dist_t t1_s8, t2_s8;
	logic  hit0_s8;
	oc_t [2:0]  oc_s8;
	dir_t [2:0] d_s8;

	assign sa = sq1_s[RT_W-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s8   <= -38'(sa.b) - $signed({2'b00, root1});
			t2_s8   <= -38'(sa.b) + $signed({2'b00, root1});
			hit0_s8 <= sa.hit;
			oc_s8   <= sa.oc;
			d_s8    <= sa.d;
		end
	end

	// Stage 9: pick the nearer root at or beyond the minimum distance
	dist_t mind;
	logic  hit_s9;
	dist_t t_s9;
	oc_t [2:0]  oc_s9;
	dir_t [2:0] d_s9;

	assign mind = $signed({7'b0, min_dist_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s9 <= hit0_s8 && !(t2_s8 < mind);
			t_s9   <= (t1_s8 < mind) ? t2_s8 : t1_s8;
			oc_s9  <= oc_s8;
			d_s9   <= d_s8;
		end
	end

	// Stage 10: d * t as two partial products
	logic signed [36:0] ph_s10 [3];
	logic signed [37:0] pl_s10 [3];
	logic       hit_s10;
	dist_t      t_s10;
	oc_t [2:0]  oc_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ph_s10[i] <= 37'(d_s9[i]) * 37'($signed(t_s9[37:19]));
				pl_s10[i] <= 38'(d_s9[i]) * 38'($signed({1'b0, t_s9[18:0]}));
			end
			hit_s10 <= hit_s9;
			t_s10   <= t_s9;
			oc_s10  <= oc_s9;
		end
	end

	// Stage 11: combine partial products
	logic signed [55:0] dt_s11 [3];
	logic       hit_s11;
	dist_t      t_s11;
	oc_t [2:0]  oc_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dt_s11[i] <= (56'(ph_s10[i]) <<< 19) + 56'(pl_s10[i]);
			end
			hit_s11 <= hit_s10;
			t_s11   <= t_s10;
			oc_s11  <= oc_s10;
		end
	end

	// Stage 12: hit point relative to center, saturated
	loc_t [2:0] loc_s12;
	logic       hit_s12;
	dist_t      t_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				loc_s12[i] <= sat41(41'(oc_s11[i]) + 41'(dt_s11[i] >>> 16));
			end
			hit_s12 <= hit_s11;
			t_s12   <= t_s11;
		end
	end

	// Stage 13: squared components
	logic [63:0] lq_s13 [3];
	loc_t [2:0]  loc_s13;
	logic        hit_s13;
	dist_t       t_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				lq_s13[i] <= 64'(mag32(loc_s12[i])) * 64'(mag32(loc_s12[i]));
			end
			loc_s13 <= loc_s12;
			hit_s13 <= hit_s12;
			t_s13   <= t_s12;
		end
	end

	// Stage 14: squared length (cannot exceed 3 * 2^62)
	logic [63:0] sq_s14;
	loc_t [2:0]  loc_s14;
	logic        hit_s14;
	dist_t       t_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s14  <= lq_s13[0] + lq_s13[1] + lq_s13[2];
			loc_s14 <= loc_s13;
			hit_s14 <= hit_s13;
			t_s14   <= t_s13;
		end
	end

	// Normal length square root with sideband line
	logic [RT_W-1:0] root2;
	sqb_t            sq2_s [RT_W];

	rsi_isqrt u_sqrt_len (
		.clk  (clk),
		.en   (adv),
		.rad  ({(SQ_W-64)'(0), sq_s14}),
		.root (root2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq2_s[0] <= '{hit: hit_s14, t: t_s14, loc: loc_s14};
			for (int k = 1; k < RT_W; k++) begin
				sq2_s[k] <= sq2_s[k-1];
			end
		end
	end

	// Normal dividers, one lane per axis
	sqb_t             sb;
	logic [DV_QW-1:0] quo [3];
	dvb_t             dv_s [DV_QW];

	assign sb = sq2_s[RT_W-1];

	for (genvar i = 0; i < 3; i++) begin : g_div
		rsi_ndiv u_div (
			.clk (clk),
			.en  (adv),
			.num (mag32(sb.loc[i])),
			.den (root2[DV_NW-1:0]),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= '{hit: sb.hit, lenz: (root2 == '0), t: sb.t, loc: sb.loc};
			for (int k = 1; k < DV_QW; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
		end
	end

	// Output register
	dvb_t        dl;
	logic [17:0] nrm [3];
	logic        hit_q;
	logic [30:0] dist_q;
	logic [17:0] nrm_q [3];
	loc_t        loc_q [3];
	logic [7:0]  mat_q;

	assign dl = dv_s[DV_QW-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dl.lenz) begin
				nrm[i] = '0;
			end else if (dl.loc[i][31]) begin
				nrm[i] = -18'(quo[i]);
			end else begin
				nrm[i] = 18'(quo[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= vd_s[DV_QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q <= dl.hit;
			if (dl.hit) begin
				dist_q <= (dl.t[37:31] != '0) ? '1 : dl.t[30:0];
				mat_q  <= material_q;
				for (int i = 0; i < 3; i++) begin
					nrm_q[i] <= nrm[i];
					loc_q[i] <= dl.loc[i];
				end
			end else begin
				dist_q <= '0;
				mat_q  <= '0;
				for (int i = 0; i < 3; i++) begin
					nrm_q[i] <= '0;
					loc_q[i] <= '0;
				end
			end
		end
	end

	assign is_hit       = hit_q;
	assign hit_distance = dist_q;
	assign normal_x     = nrm_q[0];
	assign normal_y     = nrm_q[1];
	assign normal_z     = nrm_q[2];
	assign local_x      = loc_q[0];
	assign local_y      = loc_q[1];
	assign local_z      = loc_q[2];
	assign hit_material = mat_q;

endmodule

// ===== rtl/core/rsi_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
module rsi_isqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [rsi_pkg::SQ_W-1:0] rad,
	output logic [rsi_pkg::RT_W-1:0] root
);
	import rsi_pkg::*;

	logic [SQ_W-1:0] rem_s  [RT_W-1];
	logic [RT_W-1:0] root_s [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_st
		localparam int Sh = RT_W - 1 - k;
		logic [SQ_W-1:0] rem_i;
		logic [RT_W-1:0] root_i;
		logic [SQ_W+1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign rem_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		// (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
		assign trial = ((SQ_W+2)'(root_i) << (Sh + 1)) + ((SQ_W+2)'(1) << (2 * Sh));
		assign take  = {2'b00, rem_i} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= take ? (root_i | (RT_W'(1) << Sh)) : root_i;
			end
		end

		if (k < RT_W - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_i - trial[SQ_W-1:0]) : rem_i;
				end
			end
		end
	end

	assign root = root_s[RT_W-1];

endmodule

// ===== rtl/core/rsi_ndiv.sv =====
// Pipelined restoring divider for one normal component: (num * 2^16) / den.
module rsi_ndiv (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rsi_pkg::DV_NW-1:0] num,
	input  logic [rsi_pkg::DV_NW-1:0] den,
	output logic [rsi_pkg::DV_QW-1:0] quo
);
	import rsi_pkg::*;

	logic [DV_RW-1:0] rem_s [DV_QW-1];
	logic [DV_NW-1:0] den_s [DV_QW-1];
	logic [DV_QW-1:0] q_s   [DV_QW];

	for (genvar k = 0; k < DV_QW; k++) begin : g_st
		localparam int Sh = DV_QW - 1 - k;
		logic [DV_RW-1:0] rem_i;
		logic [DV_NW-1:0] den_i;
		logic [DV_QW-1:0] q_i;
		logic [DV_RW:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_i = {num, DV_FW'(0)};
			assign den_i = den;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign q_i   = q_s[k-1];
		end

		assign trial = (DV_RW+1)'(den_i) << Sh;
		assign take  = {1'b0, rem_i} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= take ? (q_i | (DV_QW'(1) << Sh)) : q_i;
			end
		end

		if (k < DV_QW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_i - trial[DV_RW-1:0]) : rem_i;
					den_s[k] <= den_i;
				end
			end
		end
	end

	assign quo = q_s[DV_QW-1];

endmodule

// ===== rtl/core/rsi_chk.sv =====
// Port-level assertions for the ray/sphere intersection pipeline, bound to the top.
module rsi_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_ready,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       is_hit,
	input logic [30:0]                hit_distance,
	input logic signed [17:0]         normal_x,
	input logic signed [17:0]         normal_y,
	input logic signed [17:0]         normal_z,
	input logic signed [31:0]         local_x,
	input logic signed [31:0]         local_y,
	input logic signed [31:0]         local_z,
	input logic [7:0]                 hit_material
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_hit)
			&& $stable(hit_distance) && $stable(local_x) && $stable(normal_x))
		else $error("stalled result changed");

	// A miss reports all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_hit |-> hit_distance == 0 && hit_material == 0
			&& normal_x == 0 && normal_y == 0 && normal_z == 0
			&& local_x == 0 && local_y == 0 && local_z == 0)
		else $error("miss with nonzero fields");

	// Normal components stay within unit range
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_hit |-> normal_x >= -18'sd65536 && normal_x <= 18'sd65536
			&& normal_y >= -18'sd65536 && normal_y <= 18'sd65536
			&& normal_z >= -18'sd65536 && normal_z <= 18'sd65536)
		else $error("normal out of range");

	// An empty output never blocks the input side
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready && cfg_ready)
		else $error("input blocked while output empty");

endmodule

bind ray_sphere_intersect rsi_chk u_rsi_chk (.*);

// ===== test/ray_sphere_intersect_tb.sv =====
// Self-checking testbench for the ray/sphere intersection pipeline.
module ray_sphere_intersect_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsi_pkg::*;

	localparam int  LIMIT     = 400000;
	localparam int  DRAIN     = 120;
	localparam int  LONG_HOLD = 600;
	localparam logic [CFG_IW-1:0] IDX_UNUSED = 3'd7;

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [17:0] dx, dy, dz;
	} ray_t;

	typedef struct {
		logic               hit;
		logic [30:0]        distance;
		logic signed [17:0] nx, ny, nz;
		logic signed [31:0] lx, ly, lz;
		logic [7:0]         mat;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
	logic signed [17:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_hit;
	logic [30:0] hit_distance;
	logic signed [17:0] normal_x, normal_y, normal_z;
	logic signed [31:0] local_x, local_y, local_z;
	logic [7:0] hit_material;

	ray_sphere_intersect dut (.*);

	// sphere settings as seen by the predictor
	longint cen_x = 0, cen_y = 0, cen_z = 0;
	longint radius = 65536, material = 0, min_dist = 0, disc_thr = 7;

	ray_t   ray_q[$];
	hit_t   hit_q[$];
	ray_t   cur_ray;
	int     errors = 0;
	int     rays_sent = 0, results_seen = 0, hits_seen = 0;
	int     cycles = 0;
	int     tx_gap = 0, rx_gap = 0;
	bit     no_idle = 1'b0;
	bit     want_stall = 1'b0;
	int     stall_cnt = 0;
	logic   rx_hold;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [127:0] isqrt(input logic [127:0] v);
		logic [127:0] r, c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (128'd1 << i);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic hit_t hit_predict(input ray_t ry);
		hit_t res;
		longint oc[3], d[3], lc[3];
		longint b, s, t1, t2, t, len, n;
		logic signed [127:0] bw, rw, w, p, q, disc, thr, sq;
		res = '{default: '0};
		oc[0] = longint'(ry.ox) - cen_x;
		oc[1] = longint'(ry.oy) - cen_y;
		oc[2] = longint'(ry.oz) - cen_z;
		d[0] = longint'(ry.dx);
		d[1] = longint'(ry.dy);
		d[2] = longint'(ry.dz);
		b = (oc[0] * d[0] + oc[1] * d[1] + oc[2] * d[2]) >>> 16;
		bw = b;
		rw = radius;
		p = bw * bw + rw * rw;
		q = 0;
		for (int i = 0; i < 3; i++) begin
			w = oc[i];
			q = q + w * w;
		end
		disc = p - q;
		if (disc < 0)
			return res;
		thr = disc_thr;
		if (disc < (thr <<< 16))
			return res;
		s = longint'(isqrt(disc));
		t1 = -b - s;
		t2 = -b + s;
		if (t2 < min_dist)
			return res;
		t = (t1 < min_dist) ? t2 : t1;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			lc[i] = oc[i] + ((d[i] * t) >>> 16);
			if (lc[i] > 64'sd2147483647)
				lc[i] = 64'sd2147483647;
			if (lc[i] < -64'sd2147483648)
				lc[i] = -64'sd2147483648;
			w = lc[i];
			sq = sq + w * w;
		end
		len = longint'(isqrt(sq));
		res.hit = 1'b1;
		res.distance = (t > 64'sd2147483647) ? 31'h7FFFFFFF : t[30:0];
		for (int i = 0; i < 3; i++) begin
			n = 0;
			if (len != 0) begin
				n = (lc[i] * 65536) / len;
				if (n > 65536)
					n = 65536;
				if (n < -65536)
					n = -65536;
			end
			case (i)
				0: begin res.nx = n[17:0]; res.lx = lc[i][31:0]; end
				1: begin res.ny = n[17:0]; res.ly = lc[i][31:0]; end
				default: begin res.nz = n[17:0]; res.lz = lc[i][31:0]; end
			endcase
		end
		res.mat = material[7:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				hit_q.push_back(hit_predict(cur_ray));
				rays_sent++;
			end
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (ray_q.size() > 0) begin
				cur_ray = ray_q.pop_front();
				ray_origin_x <= cur_ray.ox;
				ray_origin_y <= cur_ray.oy;
				ray_origin_z <= cur_ray.oz;
				ray_dir_x <= cur_ray.dx;
				ray_dir_y <= cur_ray.dy;
				ray_dir_z <= cur_ray.dz;
				in_valid <= 1'b1;
				tx_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (want_stall && stall_cnt < LONG_HOLD)
			stall_cnt <= stall_cnt + 1;
	end
	assign rx_hold = want_stall && (stall_cnt < LONG_HOLD);

	// result monitor
	always @(posedge clk) begin
		hit_t got, exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{is_hit, hit_distance, normal_x, normal_y, normal_z,
					local_x, local_y, local_z, hit_material};
				results_seen++;
				if (is_hit)
					hits_seen++;
				if (hit_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transaction: %p", got);
				end else begin
					exp_r = hit_q.pop_front();
					if (got.hit !== exp_r.hit || got.distance !== exp_r.distance
						|| got.nx !== exp_r.nx || got.ny !== exp_r.ny
						|| got.nz !== exp_r.nz || got.lx !== exp_r.lx
						|| got.ly !== exp_r.ly || got.lz !== exp_r.lz
						|| got.mat !== exp_r.mat) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at result %0d", results_seen);
							$display("  expected %p", exp_r);
							$display("  actual   %p", got);
						end
					end
				end
			end
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("ray_sphere_intersect regression: fail");
			$finish;
		end
	end

	task automatic wait_drained(input int extra);
		while (ray_q.size() > 0 || in_valid || hit_q.size() > 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X: cen_x = longint'(signed'(val));
			REG_CENTER_Y: cen_y = longint'(signed'(val));
			REG_CENTER_Z: cen_z = longint'(signed'(val));
			REG_RADIUS:   radius = val[30:0];
			REG_MATERIAL: material = val[7:0];
			REG_MIN_DIST: min_dist = val[30:0];
			REG_DISC_THR: disc_thr = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(input logic [31:0] x, y, z, r, m, mn, th);
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
		write_reg(REG_RADIUS, r);
		write_reg(REG_MATERIAL, m);
		write_reg(REG_MIN_DIST, mn);
		write_reg(REG_DISC_THR, th);
		cfg_valid <= 1'b0;
	endtask

	function automatic ray_t mk_ray(input longint ox, oy, oz, dx, dy, dz);
		ray_t ry;
		ry.ox = ox[31:0]; ry.oy = oy[31:0]; ry.oz = oz[31:0];
		ry.dx = dx[17:0]; ry.dy = dy[17:0]; ry.dz = dz[17:0];
		return ry;
	endfunction

	function automatic ray_t noise_ray();
		return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic real urand();
		return $urandom / 4294967295.0;
	endfunction

	function automatic longint clamp32(input real v);
		if (v > 2147483647.0)
			return 64'sd2147483647;
		if (v < -2147483648.0)
			return -64'sd2147483648;
		return $rtoi(v);
	endfunction

	// ray pointed near the sphere from a random distance, sometimes from behind
	function automatic ray_t aimed_ray();
		real v[3], c[3], o[3], nrm, rr, span;
		c[0] = cen_x; c[1] = cen_y; c[2] = cen_z;
		rr = (radius == 0) ? 65536.0 : radius;
		nrm = 0.0;
		while (nrm < 0.01) begin
			for (int i = 0; i < 3; i++)
				v[i] = 2.0 * urand() - 1.0;
			nrm = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
		end
		span = rr * (10.0 * urand() - 1.5);
		for (int i = 0; i < 3; i++) begin
			v[i] = v[i] / nrm;
			o[i] = c[i] - v[i] * span + rr * (1.4 * urand() - 0.7);
		end
		return mk_ray(clamp32(o[0]), clamp32(o[1]), clamp32(o[2]),
			$rtoi(v[0] * 65536.0), $rtoi(v[1] * 65536.0), $rtoi(v[2] * 65536.0));
	endfunction

	task automatic push_mix(input int count);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				ray_q.push_back(aimed_ray());
			else
				ray_q.push_back(noise_ray());
		end
	endtask

	task automatic random_sphere();
		set_sphere($urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(0, 1 << 25) - (1 << 24),
			$urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(1 << 14, 1 << 22),
			$urandom_range(0, 255), $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 10));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes and basic hit/miss cases
		ray_q.push_back(mk_ray(0, 0, -5 * 65536, 0, 0, 65536));
		ray_q.push_back(mk_ray(0, 0, 5 * 65536, 0, 0, -65536));
		ray_q.push_back(mk_ray(0, 0, 0, 65536, 0, 0));
		ray_q.push_back(mk_ray(0, 0, 5 * 65536, 0, 0, 65536));
		ray_q.push_back(mk_ray(0, 3 * 65536, -5 * 65536, 0, 0, 65536));
		ray_q.push_back(mk_ray(65536, 0, -5 * 65536, 0, 0, 65536));
		ray_q.push_back(mk_ray(65535, 0, -5 * 65536, 0, 0, 65536));
		ray_q.push_back(mk_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			-65536, -65536, -65536));
		ray_q.push_back(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			65536, 65536, 65536));
		ray_q.push_back(mk_ray(0, -4 * 65536, 0, 0, 131071, 0));
		ray_q.push_back(mk_ray(0, 4 * 65536, 0, 0, -131072, 0));
		ray_q.push_back(mk_ray(-3 * 65536, 0, 0, 46341, 46341, 0));
		ray_q.push_back(mk_ray(-3 * 65536, -3 * 65536, 0, 46341, 46341, 0));
		ray_q.push_back(mk_ray(0, 0, -2 * 65536, 0, 0, 0));
		ray_q.push_back(mk_ray(-1, -1, -1, 131071, 131071, 131071));
		ray_q.push_back(mk_ray(32'sh55555555, 32'shAAAAAAAA, 0, 18'h15555, 18'h2AAAA, 0));
		wait_drained(DRAIN);

		// degenerate sphere: zero radius, zero threshold, zero-length normal
		write_reg(IDX_UNUSED, 32'hFFFFFFFF);
		set_sphere(0, 0, 0, 0, 8'h5A, 0, 0);
		ray_q.push_back(mk_ray(0, 0, 0, 65536, 0, 0));
		ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0));
		ray_q.push_back(mk_ray(-65536, 0, 0, 65536, 0, 0));
		ray_q.push_back(mk_ray(0, 0, 0, -65536, 65536, -65536));
		push_mix(6);
		wait_drained(DRAIN);

		// moderate sphere, receiver held off so the pipeline backs up
		random_sphere();
		no_idle = 1'b1;
		want_stall = 1'b1;
		push_mix(160);
		wait_drained(0);
		no_idle = 1'b0;
		push_mix(60);
		wait_drained(DRAIN);

		// extreme settings
		set_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 8'hFF,
			32'h7FFFFFFF, 32'h7FFFFFFF);
		push_mix(40);
		wait_drained(DRAIN);
		set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 8'h00, 0, 0);
		push_mix(40);
		wait_drained(DRAIN);

		random_sphere();
		push_mix(70);
		wait_drained(DRAIN);
		random_sphere();
		push_mix(70);
		wait_drained(DRAIN);

		$display("rays sent %0d, results checked %0d, hits %0d, across 7 sphere settings",
			rays_sent, results_seen, hits_seen);
		$display("included degenerate sphere, extreme registers and a long output stall");
		if (errors == 0)
			$display("ray_sphere_intersect regression: pass");
		else
			$display("ray_sphere_intersect regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rsi_pkg.sv
rtl/core/rsi_isqrt.sv
rtl/core/rsi_ndiv.sv
rtl/core/ray_sphere_intersect.sv
rtl/core/rsi_chk.sv
test/ray_sphere_intersect_tb.sv
